FILE: src/msgrad_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gradient color package
// Shared widths, codes, types and helpers of the multi-stop color gradient.
// ----------------------------------------------------------------------------
package msgrad_pkg;

   localparam int PHASE_W       = 32;
   localparam int V_W           = PHASE_W + 1;
   localparam int POS_W         = 17;
   localparam int CHAN_W        = 8;
   localparam int COLOR_W       = 3 * CHAN_W;
   localparam int STOP_W        = POS_W + COLOR_W;
   localparam int NUM_W         = POS_W + CHAN_W;
   localparam int NUM_STOP_REGS = 6;
   localparam int CSR_INDEX_W   = 3;
   localparam int COUNT_W       = 3;
   localparam int QUEUE_DEPTH   = 2;

   localparam int DEF_MAX_STOPS = 6;
   localparam int DEF_FRAC_BITS = 16;

   localparam logic [CSR_INDEX_W-1:0] REG_STOP_COUNT = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_MIRROR     = 3'd7;

   localparam logic CMD_DIRECT = 1'b0;
   localparam logic CMD_LOOPED = 1'b1;

   localparam logic [COLOR_W-1:0] COLOR_WHITE = {COLOR_W{1'b1}};

   typedef enum logic [1:0] {
      CH_RED,
      CH_GREEN,
      CH_BLUE
   } msgrad_chan_type;

   typedef enum logic [1:0] {
      KIND_WHITE,
      KIND_FLAT,
      KIND_BLEND
   } msgrad_kind_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_MUL,
      BACK_DIV,
      BACK_OUT
   } msgrad_back_state_type;

   typedef struct packed {
      msgrad_kind_type    kind;
      logic [COLOR_W-1:0] c1;
      logic [COLOR_W-1:0] c2;
      logic [POS_W-1:0]   d;
      logic [POS_W-1:0]   t;
   } msgrad_entry_type;

   function automatic logic [CHAN_W-1:0] chan_byte(input logic [COLOR_W-1:0] color,
                                                   input msgrad_chan_type ch);
      logic [CHAN_W-1:0] b;
      case (ch)
         CH_RED:   b = color[3*CHAN_W-1:2*CHAN_W];
         CH_GREEN: b = color[2*CHAN_W-1:CHAN_W];
         CH_BLUE:  b = color[CHAN_W-1:0];
         default:  b = '0;
      endcase
      return b;
   endfunction

endpackage

FILE: src/msgrad_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gradient request channel
// Valid/ready channel carrying the lookup command and the phase.
// ----------------------------------------------------------------------------
interface msgrad_req_if import msgrad_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               cmd;
   logic [PHASE_W-1:0] phase;

   modport source (output valid, output cmd, output phase, input ready);
   modport sink   (input valid, input cmd, input phase, output ready);
endinterface

FILE: src/msgrad_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gradient response channel
// Valid/ready channel carrying the resulting color.
// ----------------------------------------------------------------------------
interface msgrad_rsp_if import msgrad_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] red;
   logic [CHAN_W-1:0] green;
   logic [CHAN_W-1:0] blue;
   logic              no_stops;

   modport source (output valid, output red, output green, output blue, output no_stops,
                   input ready);
   modport sink   (input valid, input red, input green, input blue, input no_stops,
                   output ready);
endinterface

FILE: src/msgrad_csr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gradient configuration channel
// Valid/ready write channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface msgrad_csr_if import msgrad_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [STOP_W-1:0]      data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: src/msgrad_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gradient front end
// Holds the configuration, wraps looped phases and finds the stops around it.
// ----------------------------------------------------------------------------
module msgrad_front import msgrad_pkg::*; #(
   parameter int MAX_STOPS = DEF_MAX_STOPS,
   parameter int FRAC_BITS = DEF_FRAC_BITS
) (
   input  logic             clock,
   input  logic             reset,
   msgrad_req_if.sink       req_bus,
   msgrad_csr_if.sink       csr_bus,
   output logic             push_valid,
   input  logic             push_ready,
   output msgrad_entry_type push_entry
);

   localparam logic [PHASE_W-1:0] FRAC_MASK = PHASE_W'((64'd1 << FRAC_BITS) - 64'd1);
   localparam logic [V_W-1:0]     ONE_V     = V_W'(64'd1 << FRAC_BITS);
   localparam logic [V_W-1:0]     TWO_V     = V_W'(64'd2 << FRAC_BITS);

   logic [STOP_W-1:0]   stop_ff [MAX_STOPS];
   logic [COUNT_W-1:0]  count_ff;
   logic                mirror_ff;
   logic                a_valid_ff, a_valid_in;
   logic signed [V_W-1:0] a_v_ff, a_v_in;
   logic                accept;
   logic [V_W-1:0]      wrapped, doubled, folded;
   logic signed [V_W-1:0] v_new;

   assign csr_bus.ready = 1'b1;
   assign req_bus.ready = !a_valid_ff || push_ready;
   assign accept        = req_bus.valid && req_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_STOPS; i++) begin
            stop_ff[i] <= '0;
         end
         count_ff  <= '0;
         mirror_ff <= 1'b0;
      end else if (csr_bus.valid) begin
         for (int i = 0; i < MAX_STOPS; i++) begin
            if (csr_bus.index == CSR_INDEX_W'(i)) begin
               stop_ff[i] <= csr_bus.data;
            end
         end
         if (csr_bus.index == REG_STOP_COUNT) begin
            count_ff <= csr_bus.data[COUNT_W-1:0];
         end
         if (csr_bus.index == REG_MIRROR) begin
            mirror_ff <= csr_bus.data[0];
         end
      end
   end

   always_comb begin
      wrapped = {1'b0, req_bus.phase & FRAC_MASK};
      doubled = wrapped << 1;
      if (mirror_ff) begin
         folded = (doubled > ONE_V) ? (TWO_V - doubled) : doubled;
      end else begin
         folded = wrapped;
      end
      if (req_bus.cmd == CMD_LOOPED) begin
         v_new = $signed(folded);
      end else begin
         v_new = $signed({req_bus.phase[PHASE_W-1], req_bus.phase});
      end
      a_valid_in = a_valid_ff;
      a_v_in     = a_v_ff;
      if (req_bus.ready) begin
         a_valid_in = req_bus.valid;
      end
      if (accept) begin
         a_v_in = v_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
      a_v_ff <= a_v_in;
   end

   always_comb begin
      logic [COUNT_W-1:0]  n;
      logic                active;
      logic [POS_W-1:0]    pos;
      logic [COLOR_W-1:0]  col;
      logic signed [V_W-1:0] pos_s;
      logic                min_found, max_found, lo_found, hi_found;
      logic [POS_W-1:0]    min_pos, max_pos, lo_pos, hi_pos;
      logic [COLOR_W-1:0]  min_col, max_col, lo_col, hi_col;
      n = (count_ff > COUNT_W'(MAX_STOPS)) ? COUNT_W'(MAX_STOPS) : count_ff;
      min_found = 1'b0;
      max_found = 1'b0;
      lo_found  = 1'b0;
      hi_found  = 1'b0;
      min_pos = '0;
      max_pos = '0;
      lo_pos  = '0;
      hi_pos  = '0;
      min_col = '0;
      max_col = '0;
      lo_col  = '0;
      hi_col  = '0;
      for (int i = 0; i < MAX_STOPS; i++) begin
         active = COUNT_W'(i) < n;
         pos    = stop_ff[i][STOP_W-1 -: POS_W];
         col    = stop_ff[i][COLOR_W-1:0];
         pos_s  = $signed({{(V_W-POS_W){1'b0}}, pos});
         if (active && (!min_found || pos < min_pos)) begin
            min_found = 1'b1;
            min_pos   = pos;
            min_col   = col;
         end
         if (active && (!max_found || pos >= max_pos)) begin
            max_found = 1'b1;
            max_pos   = pos;
            max_col   = col;
         end
         if (active && pos_s < a_v_ff && (!lo_found || pos >= lo_pos)) begin
            lo_found = 1'b1;
            lo_pos   = pos;
            lo_col   = col;
         end
         if (active && pos_s >= a_v_ff && (!hi_found || pos < hi_pos)) begin
            hi_found = 1'b1;
            hi_pos   = pos;
            hi_col   = col;
         end
      end
      push_entry.c2 = hi_col;
      push_entry.d  = hi_pos - lo_pos;
      push_entry.t  = a_v_ff[POS_W-1:0] - lo_pos;
      if (n == '0) begin
         push_entry.kind = KIND_WHITE;
         push_entry.c1   = COLOR_WHITE;
      end else if (a_v_ff <= $signed({{(V_W-POS_W){1'b0}}, min_pos})) begin
         push_entry.kind = KIND_FLAT;
         push_entry.c1   = min_col;
      end else if (a_v_ff >= $signed({{(V_W-POS_W){1'b0}}, max_pos})) begin
         push_entry.kind = KIND_FLAT;
         push_entry.c1   = max_col;
      end else begin
         push_entry.kind = KIND_BLEND;
         push_entry.c1   = lo_col;
      end
   end

   assign push_valid = a_valid_ff;

endmodule

FILE: src/msgrad_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gradient work queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module msgrad_queue import msgrad_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  msgrad_entry_type push_entry,
   output logic             pop_valid,
   input  logic             pop,
   output msgrad_entry_type pop_entry
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   msgrad_entry_type mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = count_ff != CNT_W'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;
   assign pop_entry  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

FILE: src/msgrad_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gradient back end
// Blends the two stop colors per channel with one shared restoring divider.
// ----------------------------------------------------------------------------
module msgrad_back import msgrad_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             pop_valid,
   output logic             pop,
   input  msgrad_entry_type pop_entry,
   msgrad_rsp_if.source     rsp_bus
);

   localparam int K_W = $clog2(CHAN_W);

   msgrad_back_state_type state_ff, state_in;
   msgrad_entry_type      cur_ff, cur_in;
   msgrad_chan_type       ch_ff, ch_in;
   logic [K_W-1:0]        k_ff, k_in;
   logic [NUM_W-1:0]      rem_ff, rem_in;
   logic [CHAN_W-1:0]     quo_ff, quo_in;
   logic [COLOR_W-1:0]    res_ff, res_in;
   logic                  white_ff, white_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [COLOR_W-1:0]    rsp_color_ff, rsp_color_in;
   logic                  rsp_white_ff, rsp_white_in;
   logic [NUM_W-1:0]      prod_lo, prod_hi, shifted;
   logic [CHAN_W-1:0]     quo_next;
   logic                  fits;

   assign prod_lo = NUM_W'(chan_byte(cur_ff.c1, ch_ff)) * NUM_W'(cur_ff.d - cur_ff.t);
   assign prod_hi = NUM_W'(chan_byte(cur_ff.c2, ch_ff)) * NUM_W'(cur_ff.t);
   assign shifted = NUM_W'(cur_ff.d) << k_ff;
   assign fits    = rem_ff >= shifted;
   assign quo_next = {quo_ff[CHAN_W-2:0], fits};

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      ch_in        = ch_ff;
      k_in         = k_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      res_in       = res_ff;
      white_in     = white_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_color_in = rsp_color_ff;
      rsp_white_in = rsp_white_ff;
      pop          = 1'b0;
      if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         BACK_IDLE: begin
            if (pop_valid) begin
               pop      = 1'b1;
               cur_in   = pop_entry;
               ch_in    = CH_RED;
               res_in   = pop_entry.c1;
               white_in = pop_entry.kind == KIND_WHITE;
               state_in = (pop_entry.kind == KIND_BLEND) ? BACK_MUL : BACK_OUT;
            end
         end
         BACK_MUL: begin
            rem_in   = prod_lo + prod_hi;
            quo_in   = '0;
            k_in     = K_W'(CHAN_W - 1);
            state_in = BACK_DIV;
         end
         BACK_DIV: begin
            if (fits) begin
               rem_in = rem_ff - shifted;
            end
            quo_in = quo_next;
            if (k_ff == '0) begin
               case (ch_ff)
                  CH_RED:   res_in[3*CHAN_W-1:2*CHAN_W] = quo_next;
                  CH_GREEN: res_in[2*CHAN_W-1:CHAN_W]   = quo_next;
                  CH_BLUE:  res_in[CHAN_W-1:0]          = quo_next;
                  default:  res_in = res_ff;
               endcase
               case (ch_ff)
                  CH_RED: begin
                     ch_in    = CH_GREEN;
                     state_in = BACK_MUL;
                  end
                  CH_GREEN: begin
                     ch_in    = CH_BLUE;
                     state_in = BACK_MUL;
                  end
                  default: begin
                     state_in = BACK_OUT;
                  end
               endcase
            end else begin
               k_in = k_ff - 1'b1;
            end
         end
         BACK_OUT: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_color_in = res_ff;
               rsp_white_in = white_ff;
               state_in     = BACK_IDLE;
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff       <= cur_in;
      ch_ff        <= ch_in;
      k_ff         <= k_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      res_ff       <= res_in;
      white_ff     <= white_in;
      rsp_color_ff <= rsp_color_in;
      rsp_white_ff <= rsp_white_in;
   end

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.red      = rsp_color_ff[3*CHAN_W-1:2*CHAN_W];
   assign rsp_bus.green    = rsp_color_ff[2*CHAN_W-1:CHAN_W];
   assign rsp_bus.blue     = rsp_color_ff[CHAN_W-1:0];
   assign rsp_bus.no_stops = rsp_white_ff;

endmodule

FILE: src/multi_stop_color_gradient.sv
`timescale 1ns / 1ps
// A lookup between two stops takes one multiply and eight divide steps per
// channel through the single shared divider; a clamped or empty lookup skips them.
// The back end works on one lookup at a time; new requests queue up meanwhile
// until the queue is full.
// Synchronous active-high reset clears the configuration and all valid flags and empties the queue.
// ----------------------------------------------------------------------------
// Multi-stop color gradient
// Maps a fixed-point phase to an RGB color through configured gradient stops.
// ----------------------------------------------------------------------------
module multi_stop_color_gradient import msgrad_pkg::*; #(
   parameter int MAX_STOPS = DEF_MAX_STOPS,
   parameter int FRAC_BITS = DEF_FRAC_BITS
) (
   input  logic         clock,
   input  logic         reset,
   msgrad_req_if.sink   req_bus,
   msgrad_rsp_if.source rsp_bus,
   msgrad_csr_if.sink   csr_bus
);

   logic             push_valid, push_ready, pop_valid, pop;
   msgrad_entry_type push_entry, pop_entry;

   msgrad_front #(
      .MAX_STOPS (MAX_STOPS),
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .csr_bus    (csr_bus),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   msgrad_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_entry  (pop_entry)
   );

   msgrad_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop       (pop),
      .pop_entry (pop_entry),
      .rsp_bus   (rsp_bus)
   );

endmodule

FILE: src/msgrad_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gradient port checker
// Watches the request and response ports of the gradient block.
// ----------------------------------------------------------------------------
module msgrad_checker import msgrad_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [CHAN_W-1:0] rsp_red,
   input logic [CHAN_W-1:0] rsp_green,
   input logic [CHAN_W-1:0] rsp_blue,
   input logic              rsp_no_stops
);

   logic [3:0] pending_ff, pending_in;

   always_comb begin
      pending_in = pending_ff;
      if ((req_valid && req_ready) && !(rsp_valid && rsp_ready)) begin
         pending_in = pending_ff + 1'b1;
      end else if (!(req_valid && req_ready) && (rsp_valid && rsp_ready)) begin
         pending_in = pending_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_red) && $stable(rsp_green) &&
                                  $stable(rsp_blue) && $stable(rsp_no_stops))
      else $error("response changed while stalled");

   a_rsp_has_request: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 4'd0)
      else $error("response without an outstanding request");

   a_white: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_no_stops |-> rsp_red == 8'hFF && rsp_green == 8'hFF &&
                                    rsp_blue == 8'hFF)
      else $error("empty gradient did not return white");

   a_bounded: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= 4'd5)
      else $error("more requests in flight than the block can hold");

endmodule

bind multi_stop_color_gradient msgrad_checker u_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_bus.valid),
   .req_ready    (req_bus.ready),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .rsp_red      (rsp_bus.red),
   .rsp_green    (rsp_bus.green),
   .rsp_blue     (rsp_bus.blue),
   .rsp_no_stops (rsp_bus.no_stops)
);
